// ----- src/ate_pkg.sv -----
// Package with the shared types and constants of the arithmetic expression tokenizer.
`default_nettype none
package ate_pkg;

    localparam int TOKEN_LIMIT  = 256;
    localparam int LITERAL_BITS = 32;
    localparam int CntBits      = $clog2(TOKEN_LIMIT);
    localparam int QueueDepth   = 4;
    localparam int QPtrBits     = $clog2(QueueDepth);

    localparam logic [7:0] CharSpace = 8'h20;
    localparam logic [7:0] CharPlus  = 8'h2B;
    localparam logic [7:0] CharMinus = 8'h2D;
    localparam logic [7:0] CharStar  = 8'h2A;
    localparam logic [7:0] CharSlash = 8'h2F;
    localparam logic [7:0] CharOpen  = 8'h28;
    localparam logic [7:0] CharClose = 8'h29;
    localparam logic [7:0] CharZero  = 8'h30;
    localparam logic [7:0] CharNine  = 8'h39;

    typedef enum logic [2:0] {
        KIND_LITERAL  = 3'd0,
        KIND_OPERATOR = 3'd1,
        KIND_OPEN     = 3'd2,
        KIND_CLOSE    = 3'd3,
        KIND_UNKNOWN  = 3'd4,
        KIND_END      = 3'd5,
        KIND_ERROR    = 3'd6
    } t_kind;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_NONE = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        PREC_ADDITIVE = 2'd0,
        PREC_PRODUCT  = 2'd1,
        PREC_GROUP    = 2'd2,
        PREC_NONE     = 2'd3
    } t_prec;

    typedef enum logic [2:0] {
        CLS_DIGIT,
        CLS_SPACE,
        CLS_OP,
        CLS_OPEN,
        CLS_CLOSE,
        CLS_OTHER,
        CLS_END
    } t_class;

    typedef struct packed {
        t_class     cls;
        logic [3:0] digit;
        t_op        op;
        logic [7:0] raw;
    } t_item;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] lit;
        t_op         op;
        t_prec       prec;
        logic [7:0]  raw;
        logic        last;
    } t_token;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_push;

endpackage
`default_nettype wire

// ----- src/ate_ifs.sv -----
// Handshake interfaces for the character channel and the token channel.
`default_nettype none
interface ate_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       is_end;
    modport source (output valid, output character, output is_end, input ready);
    modport sink (input valid, input character, input is_end, output ready);
endinterface

interface ate_tok_if;
    logic        valid;
    logic        ready;
    logic [2:0]  token_kind;
    logic [31:0] literal_value;
    logic [2:0]  operator_code;
    logic [1:0]  precedence;
    logic [7:0]  raw_char;
    logic        last;
    modport source (output valid, output token_kind, output literal_value,
                    output operator_code, output precedence, output raw_char,
                    output last, input ready);
    modport sink (input valid, input token_kind, input literal_value,
                  input operator_code, input precedence, input raw_char,
                  input last, output ready);
endinterface
`default_nettype wire

// ----- src/ate_front.sv -----
// Front end: accepts characters and classifies each one for the queue.
`default_nettype none
module ate_front (
    ate_char_if.sink          i_chr,
    input  wire logic         i_full,
    output ate_pkg::t_push    o_push
);

    ate_pkg::t_item item;

    always_comb begin
        item.digit = i_chr.character[3:0];
        item.raw   = i_chr.character;
        item.op    = ate_pkg::OP_NONE;
        if (i_chr.is_end) begin
            item.cls = ate_pkg::CLS_END;
        end else if (i_chr.character >= ate_pkg::CharZero &&
                     i_chr.character <= ate_pkg::CharNine) begin
            item.cls   = ate_pkg::CLS_DIGIT;
            item.digit = 4'(i_chr.character - ate_pkg::CharZero);
        end else begin
            case (i_chr.character)
                ate_pkg::CharSpace: item.cls = ate_pkg::CLS_SPACE;
                ate_pkg::CharPlus: begin
                    item.cls = ate_pkg::CLS_OP;
                    item.op  = ate_pkg::OP_ADD;
                end
                ate_pkg::CharMinus: begin
                    item.cls = ate_pkg::CLS_OP;
                    item.op  = ate_pkg::OP_SUB;
                end
                ate_pkg::CharStar: begin
                    item.cls = ate_pkg::CLS_OP;
                    item.op  = ate_pkg::OP_MUL;
                end
                ate_pkg::CharSlash: begin
                    item.cls = ate_pkg::CLS_OP;
                    item.op  = ate_pkg::OP_DIV;
                end
                ate_pkg::CharOpen:  item.cls = ate_pkg::CLS_OPEN;
                ate_pkg::CharClose: item.cls = ate_pkg::CLS_CLOSE;
                default:            item.cls = ate_pkg::CLS_OTHER;
            endcase
        end
    end

    assign i_chr.ready  = !i_full;
    assign o_push.valid = i_chr.valid && !i_full;
    assign o_push.item  = item;

endmodule
`default_nettype wire

// ----- src/ate_queue.sv -----
// Short register queue of classified characters between front and back ends.
`default_nettype none
module ate_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire ate_pkg::t_push  i_push,
    output logic                 o_full,
    output logic                 o_pop_valid,
    output ate_pkg::t_item       o_pop_item,
    input  wire logic            i_pop
);

    ate_pkg::t_item                r_mem [ate_pkg::QueueDepth];
    logic [ate_pkg::QPtrBits-1:0]  r_wr;
    logic [ate_pkg::QPtrBits-1:0]  r_rd;
    logic [ate_pkg::QPtrBits:0]    r_cnt;
    logic                          do_pop;

    assign o_full      = r_cnt == (ate_pkg::QPtrBits+1)'(ate_pkg::QueueDepth);
    assign o_pop_valid = r_cnt != '0;
    assign o_pop_item  = r_mem[r_rd];
    assign do_pop      = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr <= r_wr + ate_pkg::QPtrBits'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + ate_pkg::QPtrBits'(1);
            end
            r_cnt <= r_cnt + (ate_pkg::QPtrBits+1)'(i_push.valid)
                           - (ate_pkg::QPtrBits+1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr] <= i_push.item;
        end
    end

endmodule
`default_nettype wire

// ----- src/ate_back.sv -----
// Back end: keeps the literal and token count state and emits the tokens.
`default_nettype none
module ate_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_pop_valid,
    input  wire ate_pkg::t_item  i_pop_item,
    output logic                 o_pop,
    ate_tok_if.source            o_tok
);

    localparam int LB = ate_pkg::LITERAL_BITS;
    localparam int CB = ate_pkg::CntBits;

    logic [LB-1:0]   r_acc, n_acc;
    logic            r_in_lit, n_in_lit;
    logic [CB-1:0]   r_cnt, n_cnt;
    logic            r_failed, n_failed;
    logic            r_out_valid, n_out_valid;
    ate_pkg::t_token r_out, n_out;
    logic            r_pend_valid, n_pend_valid;
    ate_pkg::t_token r_pend, n_pend;

    logic            out_free;
    logic            take;
    logic            lit_flush;
    logic            has_main;
    logic            limit_hit;
    logic [CB-1:0]   cnt_flushed;
    ate_pkg::t_token lit_tok;
    ate_pkg::t_token main_tok;

    assign out_free = !r_out_valid || o_tok.ready;
    assign take     = out_free && !r_pend_valid && i_pop_valid;
    assign o_pop    = take;

    always_comb begin
        lit_tok      = '{kind: ate_pkg::KIND_LITERAL, lit: 32'(r_acc), op: ate_pkg::OP_NONE,
                         prec: ate_pkg::PREC_NONE, raw: 8'd0, last: 1'b0};
        main_tok     = '{kind: ate_pkg::KIND_END, lit: 32'd0, op: ate_pkg::OP_NONE,
                         prec: ate_pkg::PREC_NONE, raw: 8'd0, last: 1'b1};
        lit_flush    = 1'b0;
        has_main     = 1'b0;
        cnt_flushed  = r_cnt + CB'(r_in_lit);
        limit_hit    = 1'b0;
        n_acc        = r_acc;
        n_in_lit     = r_in_lit;
        n_cnt        = r_cnt;
        n_failed     = r_failed;

        if (i_pop_item.cls == ate_pkg::CLS_END) begin
            lit_flush = r_in_lit && !r_failed;
            has_main  = 1'b1;
            n_acc     = '0;
            n_in_lit  = 1'b0;
            n_cnt     = '0;
            n_failed  = 1'b0;
        end else if (r_failed) begin
            has_main = 1'b0;
        end else if (i_pop_item.cls == ate_pkg::CLS_DIGIT) begin
            if (!r_in_lit) begin
                if (r_cnt >= CB'(ate_pkg::TOKEN_LIMIT - 1)) begin
                    has_main      = 1'b1;
                    main_tok.kind = ate_pkg::KIND_ERROR;
                    n_failed      = 1'b1;
                end else begin
                    n_in_lit = 1'b1;
                    n_acc    = LB'(i_pop_item.digit);
                end
            end else begin
                n_acc = (r_acc << 3) + (r_acc << 1) + LB'(i_pop_item.digit);
            end
        end else begin
            lit_flush = r_in_lit;
            n_in_lit  = 1'b0;
            n_acc     = '0;
            n_cnt     = cnt_flushed;
            limit_hit = cnt_flushed >= CB'(ate_pkg::TOKEN_LIMIT - 1);
            if (limit_hit) begin
                has_main      = 1'b1;
                main_tok.kind = ate_pkg::KIND_ERROR;
                n_failed      = 1'b1;
            end else begin
                has_main = i_pop_item.cls != ate_pkg::CLS_SPACE;
                if (has_main) begin
                    n_cnt = cnt_flushed + CB'(1);
                end
                case (i_pop_item.cls)
                    ate_pkg::CLS_OP: begin
                        main_tok.kind = ate_pkg::KIND_OPERATOR;
                        main_tok.op   = i_pop_item.op;
                        main_tok.prec = (i_pop_item.op == ate_pkg::OP_ADD ||
                                         i_pop_item.op == ate_pkg::OP_SUB)
                                        ? ate_pkg::PREC_ADDITIVE : ate_pkg::PREC_PRODUCT;
                    end
                    ate_pkg::CLS_OPEN: begin
                        main_tok.kind = ate_pkg::KIND_OPEN;
                        main_tok.prec = ate_pkg::PREC_GROUP;
                    end
                    ate_pkg::CLS_CLOSE: begin
                        main_tok.kind = ate_pkg::KIND_CLOSE;
                        main_tok.prec = ate_pkg::PREC_GROUP;
                    end
                    default: begin
                        main_tok.kind = ate_pkg::KIND_UNKNOWN;
                        main_tok.raw  = i_pop_item.raw;
                    end
                endcase
            end
        end
    end

    always_comb begin
        n_out        = r_out;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid && !o_tok.ready;
        n_pend_valid = r_pend_valid;
        if (out_free && r_pend_valid) begin
            n_out        = r_pend;
            n_out_valid  = 1'b1;
            n_pend_valid = 1'b0;
        end else if (take) begin
            if (lit_flush && has_main) begin
                n_out        = lit_tok;
                n_out_valid  = 1'b1;
                n_pend       = main_tok;
                n_pend_valid = 1'b1;
            end else if (lit_flush) begin
                n_out       = lit_tok;
                n_out.last  = 1'b1;
                n_out_valid = 1'b1;
            end else if (has_main) begin
                n_out       = main_tok;
                n_out_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc        <= '0;
            r_in_lit     <= 1'b0;
            r_cnt        <= '0;
            r_failed     <= 1'b0;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            if (take) begin
                r_acc    <= n_acc;
                r_in_lit <= n_in_lit;
                r_cnt    <= n_cnt;
                r_failed <= n_failed;
            end
            r_out_valid  <= n_out_valid;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_pend <= n_pend;
    end

    assign o_tok.valid         = r_out_valid;
    assign o_tok.token_kind    = r_out.kind;
    assign o_tok.literal_value = r_out.lit;
    assign o_tok.operator_code = r_out.op;
    assign o_tok.precedence    = r_out.prec;
    assign o_tok.raw_char      = r_out.raw;
    assign o_tok.last          = r_out.last;

endmodule
`default_nettype wire

// ----- src/arith_expr_tokenizer.sv -----
// Top level of the arithmetic expression tokenizer.
// The block takes an expression one character per request on i_chr, with a
// request that has is_end set closing the expression, and gives tokens on
// o_tok: literals, operators with code and precedence, brackets, unknown
// bytes, the end token and the error token when the token limit is hit.
// A request is taken at every cycle in which the four-entry queue between the
// classifier and the token engine has room, so one character per cycle flows.
// A token is registered in the output register after its character has left
// the queue. A character that closes a literal and yields a token gives two
// tokens, the literal first; the second waits in a pending register, carries
// last, and holds back the next queued character until it moves out.
// Spaces, dropped characters and digits below the token limit give no token.
// When the receiver stalls, the output register and the queue hold their
// contents and i_chr.ready falls once the queue is full.
// After reset the queue and output are empty and the literal, token count and
// failure state are clear.
`default_nettype none
module arith_expr_tokenizer (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ate_char_if.sink   i_chr,
    ate_tok_if.source  o_tok
);

    ate_pkg::t_push push;
    logic           full;
    logic           pop_valid;
    ate_pkg::t_item pop_item;
    logic           pop;

    ate_front u_front (
        .i_chr  (i_chr),
        .i_full (full),
        .o_push (push)
    );

    ate_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .o_pop_valid (pop_valid),
        .o_pop_item  (pop_item),
        .i_pop       (pop)
    );

    ate_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .i_pop_item  (pop_item),
        .o_pop       (pop),
        .o_tok       (o_tok)
    );

endmodule
`default_nettype wire
